[hdl/lpnmd_pkg.sv]
// ----------------------------------------------------------------------------
// lpnmd_pkg: shared types for the length-prefixed named message deframer
// Parse phases, result kinds and the result record that runs through the queue.
// ----------------------------------------------------------------------------
package lpnmd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned IDX_W    = 2;   // header fields are at most four bytes
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_PTR_W  = 2;
    localparam int unsigned Q_CNT_W  = 3;

    typedef enum logic [1:0] {
        PH_TOTAL   = 2'd0,
        PH_NAMELEN = 2'd1,
        PH_NAME    = 2'd2,
        PH_CONTENT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_kind             kind;
        logic              last;
        logic [LEN_W-1:0]  clen;
    } t_entry;

endpackage

[hdl/lpnmd_front.sv]
// ----------------------------------------------------------------------------
// lpnmd_front: header parser and byte classifier
// Assembles the length fields, checks them and tags every payload byte.
// ----------------------------------------------------------------------------
module lpnmd_front #(
    parameter int unsigned LEN_FIELD_BYTES      = 4,
    parameter int unsigned NAME_LEN_FIELD_BYTES = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc,
    input  logic [lpnmd_pkg::BYTE_W-1:0]        i_byte,
    output logic                                o_ent_vld,
    output lpnmd_pkg::t_entry                   o_ent
);

    localparam logic [lpnmd_pkg::IDX_W-1:0] LAST_T = lpnmd_pkg::IDX_W'(LEN_FIELD_BYTES - 1);
    localparam logic [lpnmd_pkg::IDX_W-1:0] LAST_N =
        lpnmd_pkg::IDX_W'(NAME_LEN_FIELD_BYTES - 1);
    localparam logic [lpnmd_pkg::LEN_W+1:0] HDR_BYTES =
        (lpnmd_pkg::LEN_W + 2)'(LEN_FIELD_BYTES + NAME_LEN_FIELD_BYTES);

    lpnmd_pkg::t_phase                r_phase, n_phase;
    logic [lpnmd_pkg::IDX_W-1:0]      r_idx,   n_idx;
    logic [lpnmd_pkg::LEN_W-1:0]      r_total, n_total;
    logic [lpnmd_pkg::LEN_W-1:0]      r_name,  n_name;
    logic [lpnmd_pkg::LEN_W-1:0]      r_rem,   n_rem;
    logic [lpnmd_pkg::LEN_W-1:0]      r_ccnt,  n_ccnt;

    logic [lpnmd_pkg::LEN_W-1:0]      lane;
    logic [lpnmd_pkg::LEN_W-1:0]      asm_total;
    logic [lpnmd_pkg::LEN_W-1:0]      asm_name;
    logic [lpnmd_pkg::LEN_W+1:0]      diff;
    logic                             rem_end;

    // little-endian byte lane of the current header byte
    assign lane      = {{(lpnmd_pkg::LEN_W - lpnmd_pkg::BYTE_W){1'b0}}, i_byte}
                       << {r_idx, 3'b000};
    assign asm_total = ((r_idx == '0) ? '0 : r_total) | lane;
    assign asm_name  = r_name | lane;
    // sign bit of diff flags total < header + name (need may exceed 32 bits)
    assign diff      = {2'b00, r_total} - (HDR_BYTES + {2'b00, asm_name});
    assign rem_end   = (r_rem[lpnmd_pkg::LEN_W-1:1] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lpnmd_pkg::PH_TOTAL;
            r_idx   <= '0;
            r_total <= '0;
            r_name  <= '0;
            r_rem   <= '0;
            r_ccnt  <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_total <= n_total;
            r_name  <= n_name;
            r_rem   <= n_rem;
            r_ccnt  <= n_ccnt;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_total    = r_total;
        n_name     = r_name;
        n_rem      = r_rem;
        n_ccnt     = r_ccnt;
        o_ent_vld  = 1'b0;
        o_ent.data = i_byte;
        o_ent.kind = lpnmd_pkg::KIND_NAME;
        o_ent.last = 1'b0;
        o_ent.clen = r_ccnt;
        if (i_acc) begin
            unique case (r_phase)
                lpnmd_pkg::PH_TOTAL: begin
                    n_total = asm_total;
                    if (r_idx == LAST_T) begin
                        n_idx   = '0;
                        n_name  = '0;
                        n_phase = lpnmd_pkg::PH_NAMELEN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                lpnmd_pkg::PH_NAMELEN: begin
                    n_name = asm_name;
                    if (r_idx != LAST_N) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_idx = '0;
                        if (diff[lpnmd_pkg::LEN_W+1]) begin
                            n_ccnt     = '0;
                            n_rem      = '0;
                            n_phase    = lpnmd_pkg::PH_TOTAL;
                            o_ent_vld  = 1'b1;
                            o_ent.data = '0;
                            o_ent.kind = lpnmd_pkg::KIND_ERROR;
                            o_ent.last = 1'b1;
                            o_ent.clen = '0;
                        end else begin
                            n_ccnt = diff[lpnmd_pkg::LEN_W-1:0];
                            if (asm_name != '0) begin
                                n_rem   = asm_name;
                                n_phase = lpnmd_pkg::PH_NAME;
                            end else if (diff[lpnmd_pkg::LEN_W-1:0] != '0) begin
                                n_rem   = diff[lpnmd_pkg::LEN_W-1:0];
                                n_phase = lpnmd_pkg::PH_CONTENT;
                            end else begin
                                n_rem      = '0;
                                n_phase    = lpnmd_pkg::PH_TOTAL;
                                o_ent_vld  = 1'b1;
                                o_ent.data = '0;
                                o_ent.kind = lpnmd_pkg::KIND_EMPTY;
                                o_ent.last = 1'b1;
                                o_ent.clen = '0;
                            end
                        end
                    end
                end
                lpnmd_pkg::PH_NAME: begin
                    o_ent_vld  = 1'b1;
                    o_ent.kind = lpnmd_pkg::KIND_NAME;
                    o_ent.last = rem_end && (r_ccnt == '0);
                    if (rem_end) begin
                        if (r_ccnt != '0) begin
                            n_rem   = r_ccnt;
                            n_phase = lpnmd_pkg::PH_CONTENT;
                        end else begin
                            n_rem   = '0;
                            n_phase = lpnmd_pkg::PH_TOTAL;
                        end
                    end else begin
                        n_rem = r_rem - 1'b1;
                    end
                end
                lpnmd_pkg::PH_CONTENT: begin
                    o_ent_vld  = 1'b1;
                    o_ent.kind = lpnmd_pkg::KIND_CONTENT;
                    o_ent.last = rem_end;
                    if (rem_end) begin
                        n_rem   = '0;
                        n_phase = lpnmd_pkg::PH_TOTAL;
                    end else begin
                        n_rem = r_rem - 1'b1;
                    end
                end
                default: begin
                    n_phase = lpnmd_pkg::PH_TOTAL;
                end
            endcase
        end
    end

endmodule

[hdl/lpnmd_queue.sv]
// ----------------------------------------------------------------------------
// lpnmd_queue: small result queue
// Decouples the parser from the output stage; head is read in place.
// ----------------------------------------------------------------------------
module lpnmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  lpnmd_pkg::t_entry   i_wdata,
    output logic                o_full,
    input  logic                i_rd,
    output lpnmd_pkg::t_entry   o_rdata,
    output logic                o_empty
);

    lpnmd_pkg::t_entry                  r_mem [lpnmd_pkg::Q_DEPTH];
    logic [lpnmd_pkg::Q_PTR_W-1:0]      r_wptr, n_wptr;
    logic [lpnmd_pkg::Q_PTR_W-1:0]      r_rptr, n_rptr;
    logic [lpnmd_pkg::Q_CNT_W-1:0]      r_cnt,  n_cnt;
    logic                               do_wr, do_rd;

    assign o_full  = (r_cnt == lpnmd_pkg::Q_CNT_W'(lpnmd_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = do_wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_rd ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[hdl/lpnmd_back.sv]
// ----------------------------------------------------------------------------
// lpnmd_back: result output stage
// Pulls results from the queue into the output register and hands them out.
// ----------------------------------------------------------------------------
module lpnmd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ent_vld,
    input  lpnmd_pkg::t_entry   i_ent,
    output logic                o_ent_rd,
    input  logic                i_pop,
    output logic                o_vld,
    output lpnmd_pkg::t_entry   o_ent
);

    logic               r_vld;
    lpnmd_pkg::t_entry  r_ent;
    logic               load;

    // refill whenever the register is free or being drained this cycle
    assign load     = !r_vld || i_pop;
    assign o_ent_rd = load && i_ent_vld;
    assign o_vld    = r_vld;
    assign o_ent    = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= i_ent_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ent_rd) begin
            r_ent <= i_ent;
        end
    end

endmodule

[hdl/length_prefixed_named_message_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_named_message_deframer: byte stream to tagged message bytes
// Splits a framed byte stream into named messages and emits tagged results.
// ----------------------------------------------------------------------------
// Push one received byte per cycle; the block takes a byte every cycle while
// full is low. Each message is a little-endian total length
// (LEN_FIELD_BYTES), a little-endian name length (NAME_LEN_FIELD_BYTES), the
// name bytes and the content bytes; the total counts all four parts. Header
// bytes give no result. Each name or content byte gives one result tagged by
// kind, with the content length of its message alongside, and the final
// result of a message has out_last set. A message with no name and no
// content gives one empty-message marker; a total length too small for the
// header plus the name gives one bad-length result and parsing restarts at
// the next total-length field. A result goes through the queue and the output
// register. Throughput is one byte per cycle, set by the parser doing one
// header-assembly or counter step per byte; full rises only when the
// four-entry result queue is full, i.e. when the consumer stops popping.
// ----------------------------------------------------------------------------
module length_prefixed_named_message_deframer #(
    parameter int unsigned LEN_FIELD_BYTES      = 4,
    parameter int unsigned NAME_LEN_FIELD_BYTES = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input, queue style
    input  logic                            push,
    output logic                            full,
    input  logic [lpnmd_pkg::BYTE_W-1:0]    i_rx_byte,
    // result output, queue style
    output logic                            empty,
    input  logic                            pop,
    output logic [lpnmd_pkg::BYTE_W-1:0]    o_out_byte,
    output logic [1:0]                      o_out_kind,
    output logic                            o_out_last,
    output logic [lpnmd_pkg::LEN_W-1:0]     o_content_length
);

    logic               acc;
    logic               ent_vld;
    lpnmd_pkg::t_entry  ent;
    logic               q_full;
    logic               q_empty;
    logic               q_rd;
    lpnmd_pkg::t_entry  q_head;
    logic               out_vld;
    lpnmd_pkg::t_entry  out_ent;

    // A byte request is taken whenever the queue has room. The parser only
    // writes the queue in the cycle it accepts, so a non-full queue always
    // has space for the one result a byte can cause.
    assign full = q_full;
    assign acc  = push && !q_full;

    // Front: header assembly, length check and byte classification.
    lpnmd_front #(
        .LEN_FIELD_BYTES      (LEN_FIELD_BYTES),
        .NAME_LEN_FIELD_BYTES (NAME_LEN_FIELD_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_byte    (i_rx_byte),
        .o_ent_vld (ent_vld),
        .o_ent     (ent)
    );

    // Short queue between the parser and the output stage.
    lpnmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (ent_vld),
        .i_wdata (ent),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_head),
        .o_empty (q_empty)
    );

    // Back: registered result, refilled in the same cycle it is popped.
    lpnmd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ent_vld (!q_empty),
        .i_ent     (q_head),
        .o_ent_rd  (q_rd),
        .i_pop     (pop),
        .o_vld     (out_vld),
        .o_ent     (out_ent)
    );

    assign empty            = !out_vld;
    assign o_out_byte       = out_ent.data;
    assign o_out_kind       = out_ent.kind;
    assign o_out_last       = out_ent.last;
    assign o_content_length = out_ent.clen;

endmodule
